/* hw/rtl/pid_sc_pkg.sv */
package pid_sc_pkg;

  localparam int unsigned ErrW        = 17;
  localparam int unsigned SumW        = 32;
  localparam int unsigned DriveW      = 16;
  localparam int unsigned GainW       = 16;
  localparam int unsigned LimitW      = 15;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned GainFracBits = 8;
  // wide enough for gain_i * error_sum plus the two smaller products
  localparam int unsigned AccW        = 50;

  localparam logic [LimitW-1:0] LimitReset = 15'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    RegPidMode     = 3'd0,
    RegGainP       = 3'd1,
    RegGainI       = 3'd2,
    RegGainD       = 3'd3,
    RegDeadBand    = 3'd4,
    RegOutputLimit = 3'd5
  } reg_idx_e;

  typedef enum logic {
    ModePositional  = 1'b0,
    ModeIncremental = 1'b1
  } pid_mode_e;

  typedef struct packed {
    pid_mode_e                 pid_mode;
    logic signed [GainW-1:0]   gain_p;
    logic signed [GainW-1:0]   gain_i;
    logic signed [GainW-1:0]   gain_d;
    logic [15:0]               dead_band;
    logic [LimitW-1:0]         output_limit;
  } cfg_t;

  typedef struct packed {
    logic                      updated;
    logic signed [DriveW-1:0]  drive;
    logic signed [SumW-1:0]    sum_d;
  } law_res_t;

endpackage

/* hw/rtl/pid_sc_cfg.sv */
module pid_sc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pid_sc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pid_sc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output pid_sc_pkg::cfg_t                   cfg_o
);
  import pid_sc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPidMode:     cfg_d.pid_mode     = pid_mode_e'(cfg_wdata_i[0]);
        RegGainP:       cfg_d.gain_p       = cfg_wdata_i;
        RegGainI:       cfg_d.gain_i       = cfg_wdata_i;
        RegGainD:       cfg_d.gain_d       = cfg_wdata_i;
        RegDeadBand:    cfg_d.dead_band    = cfg_wdata_i;
        RegOutputLimit: cfg_d.output_limit = cfg_wdata_i[LimitW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pid_mode     <= ModePositional;
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.dead_band    <= '0;
      cfg_q.output_limit <= LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/pid_sc_law.sv */
module pid_sc_law (
  input  pid_sc_pkg::cfg_t                          cfg_i,
  input  logic signed [pid_sc_pkg::ErrW-1:0]        err_i,
  input  logic signed [pid_sc_pkg::ErrW-1:0]        err1_i,
  input  logic signed [pid_sc_pkg::ErrW-1:0]        err2_i,
  input  logic signed [pid_sc_pkg::SumW-1:0]        sum_i,
  input  logic signed [pid_sc_pkg::DriveW-1:0]      hold_i,
  output pid_sc_pkg::law_res_t                      res_o
);
  import pid_sc_pkg::*;

  logic signed [ErrW:0]          diff1;
  logic signed [ErrW+1:0]        diff2;
  logic signed [ErrW+1:0]        op_a;
  logic signed [ErrW+1:0]        op_b;
  logic signed [SumW-1:0]        op_c;
  logic signed [GainW+ErrW+1:0]  prod_a;
  logic signed [GainW+ErrW+1:0]  prod_b;
  logic signed [GainW+SumW-1:0]  prod_c;
  logic signed [AccW-1:0]        acc;
  logic signed [AccW-1:0]        shifted;
  logic signed [AccW-1:0]        base;
  logic signed [AccW-1:0]        raw;
  logic signed [AccW-1:0]        lim;
  logic signed [AccW-1:0]        clamped;
  logic [ErrW-1:0]               mag;
  logic                          in_band;
  logic signed [SumW:0]          sum_wide;
  logic signed [SumW-1:0]        sum_sat;
  logic                          incr;

  assign incr  = (cfg_i.pid_mode == ModeIncremental);
  assign diff1 = (ErrW+1)'(err_i) - (ErrW+1)'(err1_i);
  assign diff2 = (ErrW+2)'(err_i) - ((ErrW+2)'(err1_i) <<< 1) + (ErrW+2)'(err2_i);

  // share the three multipliers between the two laws
  assign op_a = incr ? (ErrW+2)'(diff1) : (ErrW+2)'(err_i);
  assign op_b = incr ? diff2 : (ErrW+2)'(diff1);
  assign op_c = incr ? SumW'(err_i) : sum_i;

  assign prod_a = cfg_i.gain_p * op_a;
  assign prod_b = cfg_i.gain_d * op_b;
  assign prod_c = cfg_i.gain_i * op_c;

  assign acc     = AccW'(prod_a) + AccW'(prod_b) + AccW'(prod_c);
  // arithmetic shift floors towards minus infinity
  assign shifted = acc >>> GainFracBits;
  assign base    = incr ? AccW'(hold_i) : '0;
  assign raw     = shifted + base;
  assign lim     = AccW'({1'b0, cfg_i.output_limit});

  always_comb begin
    if (raw > lim) begin
      clamped = lim;
    end else if (raw < -lim) begin
      clamped = -lim;
    end else begin
      clamped = raw;
    end
  end

  assign mag     = err_i[ErrW-1] ? ErrW'(-err_i) : ErrW'(err_i);
  assign in_band = (cfg_i.dead_band != '0) && (mag < {1'b0, cfg_i.dead_band});

  assign sum_wide = (SumW+1)'(sum_i) + (SumW+1)'(err_i);

  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = {sum_wide[SumW], {(SumW-1){~sum_wide[SumW]}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  always_comb begin
    res_o.updated = ~in_band;
    res_o.drive   = in_band ? hold_i : clamped[DriveW-1:0];
    res_o.sum_d   = (in_band || incr) ? sum_i : sum_sat;
  end

endmodule

/* hw/rtl/pid_speed_controller.sv */
// Speed PID controller, positional or incremental law.
//
// Input channel: in_valid_i / in_ready_o carry one item, a measured and a
// target speed. Output channel: out_valid_o / out_ready_i carry one result,
// the clamped drive and a flag that is low when the error lay in the deadband.
// Configuration: a write at cfg_we_i sets register cfg_idx_i; write only while
// no item is in flight.
//
// Pipeline: an accepted item goes to the input register, its result to the
// result register, from which the receiver takes it. Throughput: one item
// per cycle while the receiver does not stall; the controller state is
// written at the same edge as the result register, so the following item
// already sees it.
//
// When the receiver stalls, the result holds and one more item may wait in
// the input register; in_ready_o drops only when both are full.
// Reset clears the error history, the error sum and the held drive, sets the
// gains to zero, the mode to positional and the drive limit to 16384.
module pid_speed_controller (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pid_sc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pid_sc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [15:0]                     measured_speed_i,
  input  logic signed [15:0]                     target_speed_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [pid_sc_pkg::DriveW-1:0]   drive_value_o,
  output logic                                   updated_o
);
  import pid_sc_pkg::*;

  cfg_t                      cfg;
  law_res_t                  res;

  logic                      in_vld_q;
  logic signed [ErrW-1:0]    err_q;
  logic                      out_vld_q;
  logic signed [DriveW-1:0]  drive_q;
  logic                      upd_q;

  logic signed [ErrW-1:0]    err1_q, err2_q;
  logic signed [SumW-1:0]    sum_q;
  logic signed [DriveW-1:0]  hold_q;

  logic                      advance;
  logic                      accept;

  pid_sc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pid_sc_law u_law (
    .cfg_i  (cfg),
    .err_i  (err_q),
    .err1_i (err1_q),
    .err2_i (err2_q),
    .sum_i  (sum_q),
    .hold_i (hold_q),
    .res_o  (res)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      err1_q    <= '0;
      err2_q    <= '0;
      sum_q     <= '0;
      hold_q    <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      // a deadband item leaves the state alone
      if (advance && res.updated) begin
        hold_q <= res.drive;
        err2_q <= err1_q;
        err1_q <= err_q;
        sum_q  <= res.sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= ErrW'(target_speed_i) - ErrW'(measured_speed_i);
    end
    if (advance) begin
      drive_q <= res.drive;
      upd_q   <= res.updated;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign drive_value_o = drive_q;
  assign updated_o     = upd_q;

endmodule

/* hw/rtl/pid_sc_checker.sv */
module pid_sc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] drive_value_o,
  input logic               updated_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o)
      && $stable(updated_o))
    else $error("result changed while stalled");

  // with the output side free the input side never blocks
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output empty");

  // an accepted item reaches the output once the result register is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("result missing after item");

  // the clamp is symmetric and at most 32767
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_value_o != 16'sh8000)
    else $error("drive outside symmetric clamp");

endmodule

bind pid_speed_controller pid_sc_checker u_pid_sc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_value_o (drive_value_o),
  .updated_o     (updated_o)
);
